// ----- rtl/plist_pkg.sv -----
// Shared types and constants for the positional list engine.
// Used by plist_ctrl, plist_dp and positional_list_engine; depends on nothing.
`default_nettype none

package plist_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int MODE_W = 4;
    localparam int POS_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MD_INS_HEAD = 4'd0,
        MD_INS_TAIL = 4'd1,
        MD_INS_AT   = 4'd2,
        MD_RM_HEAD  = 4'd3,
        MD_RM_TAIL  = 4'd4,
        MD_RM_AT    = 4'd5,
        MD_READ     = 4'd6,
        MD_REPLACE  = 4'd7,
        MD_EXISTS   = 4'd8,
        MD_EQUAL_AT = 4'd9,
        MD_SWAP     = 4'd10,
        MD_CLEAR    = 4'd11
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_PUT,
        S_RESP
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic put;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic scan_need;
        logic put_need;
        logic scan_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/plist_ctrl.sv -----
// Sequencer for the positional list engine: check, scan, drain, put, respond.
// Depends on plist_pkg.
`default_nettype none

module plist_ctrl
    import plist_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output logic          busy,
    output ctl_cmd_t      cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.ok && stat.scan_need)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.ok && stat.put_need)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = stat.put_need ? S_PUT : S_RESP;
            end
            S_PUT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_DRAIN:
            begin
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
            end
            S_RESP:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/plist_dp.sv -----
// Datapath of the positional list engine: entry memory, count, scan index,
// command decode and result registers. Depends on plist_pkg.
`default_nettype none

module plist_dp
    import plist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          cmd,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [WIDTH-1:0]  value,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [POS_W-1:0]  other_position,
    output dp_stat_t               stat,
    output logic                   done,
    output logic [WIDTH-1:0]       read_data,
    output logic                   flag,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       count
);

    logic [WIDTH-1:0] mem [DEPTH];

    mode_t            mode_reg;
    logic [WIDTH-1:0] val_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] pos2_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] end_reg;
    logic [IDX_W-1:0] end_next;
    status_t          st_reg;
    status_t          chk_st;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic [WIDTH-1:0] hold_reg;
    logic [WIDTH-1:0] res_data_reg;
    logic             flag_reg;
    logic             done_reg;

    logic             empty;
    logic             full;
    logic             pos_in;
    logic             pos2_in;
    status_t          bad1;
    status_t          bad2;
    logic [CNT_W-1:0] cnt_m1;
    logic             scan_need;
    logic             put_need;
    logic             is_ins;
    logic             is_rm;
    logic             is_swap;
    logic             hit;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [WIDTH-1:0] wdata;

    // command decode and range checks on the latched item
    always_comb
    begin
        empty   = (count_reg == '0);
        full    = (count_reg == CNT_W'(DEPTH));
        pos_in  = ({1'b0, pos_reg} < count_reg);
        pos2_in = ({1'b0, pos2_reg} < count_reg);
        bad1    = empty ? ST_EMPTY : (pos_in ? ST_OK : ST_RANGE);
        bad2    = empty ? ST_EMPTY : (pos2_in ? ST_OK : ST_RANGE);
        cnt_m1  = count_reg - CNT_W'(1);
        is_ins  = 1'b0;
        is_rm   = 1'b0;
        is_swap = 1'b0;
        chk_st    = ST_OK;
        pos_next  = pos_reg;
        scan_need = 1'b0;
        put_need  = 1'b0;
        idx_next  = pos_reg;
        end_next  = pos_reg;
        case (mode_reg)
            MD_INS_HEAD, MD_INS_TAIL, MD_INS_AT:
            begin
                is_ins   = 1'b1;
                put_need = 1'b1;
                if (mode_reg == MD_INS_HEAD)
                begin
                    pos_next = '0;
                end
                else if (mode_reg == MD_INS_TAIL)
                begin
                    pos_next = count_reg[IDX_W-1:0];
                end
                if (full)
                begin
                    chk_st = ST_FULL;
                end
                else if (mode_reg == MD_INS_AT && {1'b0, pos_reg} > count_reg)
                begin
                    chk_st = ST_RANGE;
                end
                // move entries pos .. count-1 up, walking down from the tail
                scan_need = (count_reg > {1'b0, pos_next});
                idx_next  = cnt_m1[IDX_W-1:0];
                end_next  = pos_next;
            end
            MD_RM_HEAD, MD_RM_TAIL, MD_RM_AT:
            begin
                is_rm = 1'b1;
                if (mode_reg == MD_RM_HEAD)
                begin
                    pos_next = '0;
                end
                else if (mode_reg == MD_RM_TAIL)
                begin
                    pos_next = cnt_m1[IDX_W-1:0];
                end
                chk_st    = (mode_reg == MD_RM_AT) ? bad1 : (empty ? ST_EMPTY : ST_OK);
                scan_need = (({1'b0, pos_next} + CNT_W'(1)) < count_reg);
                idx_next  = pos_next + IDX_W'(1);
                end_next  = cnt_m1[IDX_W-1:0];
            end
            MD_READ, MD_EQUAL_AT:
            begin
                chk_st    = bad1;
                scan_need = 1'b1;
            end
            MD_REPLACE:
            begin
                chk_st   = bad1;
                put_need = 1'b1;
            end
            MD_EXISTS:
            begin
                scan_need = !empty;
                idx_next  = '0;
                end_next  = cnt_m1[IDX_W-1:0];
            end
            MD_SWAP:
            begin
                is_swap = 1'b1;
                if (pos_reg != pos2_reg)
                begin
                    chk_st = (bad1 != ST_OK) ? bad1 : bad2;
                end
                scan_need = (pos_reg != pos2_reg);
                put_need  = scan_need;
                end_next  = pos2_reg;
            end
            MD_CLEAR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign stat.ok        = (chk_st == ST_OK);
    assign stat.scan_need = scan_need;
    assign stat.put_need  = put_need;
    assign stat.scan_last = (idx_reg == end_reg);

    assign hit = (rd_data_reg == val_reg);

    // single write port: moves and the swap's first write-back come from the
    // read pipeline, the final store comes from the put step
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = rd_data_reg;
        if (cmd.put)
        begin
            we    = 1'b1;
            waddr = is_swap ? pos2_reg : pos_reg;
            wdata = is_swap ? hold_reg : val_reg;
        end
        else if (rd_pend_reg && is_ins)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg + IDX_W'(1);
        end
        else if (rd_pend_reg && is_rm)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg - IDX_W'(1);
        end
        else if (rd_pend_reg && is_swap && rd_addr_reg != pos_reg)
        begin
            we    = 1'b1;
            waddr = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (st_reg == ST_OK)
        begin
            if (is_ins)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (is_rm)
            begin
                count_next = cnt_m1;
            end
            else if (mode_reg == MD_CLEAR)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan;
            done_reg    <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode_t'(mode);
            val_reg      <= value;
            pos_reg      <= position[IDX_W-1:0];
            pos2_reg     <= other_position[IDX_W-1:0];
            res_data_reg <= '0;
            flag_reg     <= 1'b0;
        end
        if (cmd.check)
        begin
            st_reg  <= chk_st;
            pos_reg <= pos_next;
            idx_reg <= idx_next;
            end_reg <= end_next;
        end
        if (cmd.scan)
        begin
            rd_addr_reg <= idx_reg;
            if (is_swap)
            begin
                idx_reg <= pos2_reg;
            end
            else if (is_ins)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (rd_pend_reg)
        begin
            if (mode_reg == MD_READ)
            begin
                res_data_reg <= rd_data_reg;
            end
            if ((mode_reg == MD_EXISTS || mode_reg == MD_EQUAL_AT) && hit)
            begin
                flag_reg <= 1'b1;
            end
            if (is_swap && rd_addr_reg == pos_reg)
            begin
                hold_reg <= rd_data_reg;
            end
        end
    end

    assign done      = done_reg;
    assign read_data = res_data_reg;
    assign flag      = flag_reg;
    assign status    = st_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: sequencer plus datapath.
// Depends on plist_pkg, plist_ctrl and plist_dp.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------
//  command  | start / busy     | mode, value, position, other_position
//  result   | done (1 cycle)   | read_data, flag, status, count
//
// Each item passes a check step, then a scan through the entry memory (one entry per
// cycle) and a drain step when entries are walked, then a store step when an entry
// is written, and last a respond step. busy is low again in the cycle done is high,
// so the next item may be taken then. Reset empties the list at once; entry contents
// are left as they are. done is high for a single cycle; read_data and flag hold
// until the next command is taken.
`default_nettype none

module positional_list_engine
    import plist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [WIDTH-1:0]  value,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [POS_W-1:0]  other_position,
    output logic                   done,
    output logic [WIDTH-1:0]       read_data,
    output logic                   flag,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       count
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    plist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    plist_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .value          (value),
        .position       (position),
        .other_position (other_position),
        .stat           (stat),
        .done           (done),
        .read_data      (read_data),
        .flag           (flag),
        .status         (status),
        .count          (count)
    );

endmodule

`default_nettype wire

// ----- sim/plist_reply_check.sv -----
// Reply checker for the positional list engine: keeps its own copy of the list,
// predicts the reply to every accepted command and compares it with done/reply ports.
// Depends on plist_pkg for widths, command and status codes.
`timescale 1ns / 1ps

module plist_reply_check
    import plist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [WIDTH-1:0]  value,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [POS_W-1:0]  other_position,
    input  wire logic              done,
    input  wire logic [WIDTH-1:0]  read_data,
    input  wire logic              flag,
    input  wire logic [1:0]        status,
    input  wire logic [CNT_W-1:0]  count,
    output int                     errors,
    output int                     pending,
    output int                     replies,
    output int                     list_len
);

    typedef struct {
        logic [WIDTH-1:0] data;
        logic             hit;
        status_t          st;
        logic [CNT_W-1:0] len;
    } list_reply_t;

    logic [WIDTH-1:0] entries [DEPTH];
    int               held_count = 0;
    list_reply_t      replies_due [$];
    int               fails = 0;
    int               seen = 0;

    initial
    begin
        errors = 0;
        pending = 0;
        replies = 0;
        list_len = 0;
    end

    function automatic void shift_in(input int at, input logic [WIDTH-1:0] v);
        int i;
        for (i = held_count; i > at; i--)
            entries[IDX_W'(i)] = entries[IDX_W'(i - 1)];
        entries[IDX_W'(at)] = v;
        held_count++;
    endfunction

    function automatic void shift_out(input int at);
        int i;
        for (i = at; i + 1 < held_count; i++)
            entries[IDX_W'(i)] = entries[IDX_W'(i + 1)];
        held_count--;
    endfunction

    function automatic status_t slot_status(input int at);
        if (held_count == 0)
            return ST_EMPTY;
        if (at >= held_count)
            return ST_RANGE;
        return ST_OK;
    endfunction

    function automatic list_reply_t apply_command(
        input logic [MODE_W-1:0] md,
        input logic [WIDTH-1:0]  v,
        input logic [POS_W-1:0]  p,
        input logic [POS_W-1:0]  q
    );
        list_reply_t      r;
        logic [WIDTH-1:0] t;
        int               a;
        int               b;
        int               i;
        a = int'(p);
        b = int'(q);
        r.data = '0;
        r.hit = 1'b0;
        r.st = ST_OK;
        case (md)
            MD_INS_HEAD, MD_INS_TAIL, MD_INS_AT:
            begin
                // a full list refuses before the position is looked at
                if (held_count >= DEPTH)
                    r.st = ST_FULL;
                else if (md == MD_INS_HEAD)
                    shift_in(0, v);
                else if (md == MD_INS_TAIL)
                    shift_in(held_count, v);
                else if (a > held_count)
                    r.st = ST_RANGE;
                else
                    shift_in(a, v);
            end
            MD_RM_HEAD, MD_RM_TAIL:
            begin
                if (held_count == 0)
                    r.st = ST_EMPTY;
                else
                    shift_out(md == MD_RM_HEAD ? 0 : held_count - 1);
            end
            MD_RM_AT:
            begin
                r.st = slot_status(a);
                if (r.st == ST_OK)
                    shift_out(a);
            end
            MD_READ:
            begin
                r.st = slot_status(a);
                if (r.st == ST_OK)
                    r.data = entries[IDX_W'(a)];
            end
            MD_REPLACE:
            begin
                r.st = slot_status(a);
                if (r.st == ST_OK)
                    entries[IDX_W'(a)] = v;
            end
            MD_EXISTS:
            begin
                for (i = 0; i < held_count; i++)
                    if (entries[IDX_W'(i)] == v)
                        r.hit = 1'b1;
            end
            MD_EQUAL_AT:
            begin
                r.st = slot_status(a);
                if (r.st == ST_OK && entries[IDX_W'(a)] == v)
                    r.hit = 1'b1;
            end
            MD_SWAP:
            begin
                // equal positions are a no-op whatever the list holds
                if (a != b)
                begin
                    r.st = slot_status(a);
                    if (r.st == ST_OK)
                        r.st = slot_status(b);
                    if (r.st == ST_OK)
                    begin
                        t = entries[IDX_W'(a)];
                        entries[IDX_W'(a)] = entries[IDX_W'(b)];
                        entries[IDX_W'(b)] = t;
                    end
                end
            end
            MD_CLEAR:
                held_count = 0;
            default:
                ;
        endcase
        r.len = CNT_W'(held_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t due;
        int          bad;
        if (!rst_n)
        begin
            held_count = 0;
            replies_due.delete();
            pending <= 0;
            list_len <= 0;
        end
        else
        begin
            // settle the outgoing reply first: the next item may be taken on the same edge
            if (done)
            begin
                seen++;
                if (replies_due.size() == 0)
                begin
                    $display("%0t ns: reply with none expected, got data %h flag %b",
                             $time, read_data, flag);
                    $display("%0t ns:   status %0d count %0d", $time, status, count);
                    fails++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    bad = 0;
                    if (read_data !== due.data)
                    begin
                        $display("%0t ns: read_data expected %h, got %h",
                                 $time, due.data, read_data);
                        bad++;
                    end
                    if (flag !== due.hit)
                    begin
                        $display("%0t ns: flag expected %b, got %b", $time, due.hit, flag);
                        bad++;
                    end
                    if (status !== due.st)
                    begin
                        $display("%0t ns: status expected %0d, got %0d",
                                 $time, due.st, status);
                        bad++;
                    end
                    if (count !== due.len)
                    begin
                        $display("%0t ns: count expected %0d, got %0d",
                                 $time, due.len, count);
                        bad++;
                    end
                    fails += bad;
                end
            end
            if (start && !busy)
                replies_due.push_back(apply_command(mode, value, position, other_position));
            pending <= replies_due.size();
            list_len <= held_count;
            errors <= fails;
            replies <= seen;
        end
    end

endmodule

// ----- sim/positional_list_engine_test.sv -----
// Top of the positional list engine testbench: clock, reset and command stimulus.
// Depends on plist_pkg, the engine RTL and plist_reply_check, which does the checking.
`timescale 1ns / 1ps

module positional_list_engine_test;
    import plist_pkg::*;

    localparam logic [MODE_W-1:0] MD_UNUSED_FIRST = 4'd12;
    localparam logic [MODE_W-1:0] MD_UNUSED_LAST  = 4'd15;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 25;
    localparam int RUN_LIMIT     = 500000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [MODE_W-1:0] mode = '0;
    logic [WIDTH-1:0]  value = '0;
    logic [POS_W-1:0]  position = '0;
    logic [POS_W-1:0]  other_position = '0;
    logic              busy;
    logic              done;
    logic [WIDTH-1:0]  read_data;
    logic              flag;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count;

    int errors;
    int pending;
    int replies;
    int list_len;
    int sent = 0;
    int cycles = 0;

    always #2 clk = ~clk;

    positional_list_engine DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .value          (value),
        .position       (position),
        .other_position (other_position),
        .done           (done),
        .read_data      (read_data),
        .flag           (flag),
        .status         (status),
        .count          (count)
    );

    plist_reply_check reply_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .value          (value),
        .position       (position),
        .other_position (other_position),
        .done           (done),
        .read_data      (read_data),
        .flag           (flag),
        .status         (status),
        .count          (count),
        .errors         (errors),
        .pending        (pending),
        .replies        (replies),
        .list_len       (list_len)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("positional_list_engine_test: errors");
            $finish;
        end
    end

    // Present one command and hold it until the engine takes it.
    task automatic issue(input logic [MODE_W-1:0] md, input logic [WIDTH-1:0] v,
                         input logic [POS_W-1:0] p, input logic [POS_W-1:0] q);
        start <= 1'b1;
        mode <= md;
        value <= v;
        position <= p;
        other_position <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [WIDTH-1:0]  pool [8];
        logic [MODE_W-1:0] md;
        logic [WIDTH-1:0]  v;
        logic [POS_W-1:0]  p;
        logic [POS_W-1:0]  q;
        int                k;
        int                r;
        int                hi;
        int                kind;
        int                phase;
        int                burst_left;
        int                gap;
        int                directed_n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every command that needs an entry
        issue(MD_RM_HEAD, 32'h0, 4'd0, 4'd0);
        issue(MD_RM_TAIL, 32'h0, 4'd0, 4'd0);
        issue(MD_RM_AT, 32'h0, 4'd0, 4'd0);
        issue(MD_READ, 32'h0, 4'd0, 4'd0);
        issue(MD_REPLACE, 32'h1, 4'd0, 4'd0);
        issue(MD_EXISTS, 32'h0, 4'd0, 4'd0);
        issue(MD_EQUAL_AT, 32'h0, 4'd0, 4'd0);
        issue(MD_SWAP, 32'h0, 4'd0, 4'd1);
        issue(MD_SWAP, 32'h0, 4'd7, 4'd7);
        issue(MD_INS_AT, 32'h0, 4'd1, 4'd0);
        // build a short list, append through insert-at-count
        issue(MD_INS_HEAD, 32'h0000_0000, 4'd0, 4'd0);
        issue(MD_INS_TAIL, 32'hFFFF_FFFF, 4'd0, 4'd0);
        issue(MD_INS_AT, 32'hA5A5_A5A5, 4'd1, 4'd0);
        issue(MD_INS_AT, 32'h5A5A_5A5A, 4'd3, 4'd0);
        issue(MD_READ, 32'h0, 4'd15, 4'd0);
        issue(MD_READ, 32'h0, 4'd2, 4'd0);
        issue(MD_REPLACE, 32'h8000_0001, 4'd0, 4'd15);
        issue(MD_EXISTS, 32'hFFFF_FFFF, 4'd0, 4'd0);
        issue(MD_EQUAL_AT, 32'hA5A5_A5A5, 4'd1, 4'd0);
        issue(MD_EQUAL_AT, 32'hA5A5_A5A5, 4'd15, 4'd0);
        issue(MD_SWAP, 32'h0, 4'd0, 4'd3);
        issue(MD_SWAP, 32'h0, 4'd3, 4'd15);
        issue(MD_UNUSED_FIRST, 32'hFFFF_FFFF, 4'd15, 4'd15);
        issue(MD_UNUSED_LAST, 32'h0, 4'd0, 4'd0);
        issue(MD_RM_AT, 32'h0, 4'd1, 4'd0);
        issue(MD_RM_TAIL, 32'h0, 4'd0, 4'd0);
        issue(MD_CLEAR, 32'h0, 4'd0, 4'd0);
        directed_n = sent;
        wait_for_replies();

        // small value pool so that searches and compares hit often
        pool[0] = '0;
        pool[1] = '1;
        for (k = 2; k < 8; k++)
            pool[k] = $urandom;

        burst_left = 0;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            phase = k / PHASE_ITEMS;
            // fill, mix, drain, mix
            kind = phase % 4;
            if (k != 0 && k % PHASE_ITEMS == 0)
                wait_for_replies();

            r = $urandom_range(99);
            case (kind)
                0:
                    md = (r < 60) ? MODE_W'($urandom_range(MD_INS_HEAD, MD_INS_AT)) :
                         (r < 70) ? MODE_W'($urandom_range(MD_RM_HEAD, MD_RM_AT)) :
                                    MODE_W'($urandom_range(MD_READ, MD_SWAP));
                2:
                    md = (r < 15) ? MODE_W'($urandom_range(MD_INS_HEAD, MD_INS_AT)) :
                         (r < 65) ? MODE_W'($urandom_range(MD_RM_HEAD, MD_RM_AT)) :
                                    MODE_W'($urandom_range(MD_READ, MD_SWAP));
                default:
                    md = (r < 30) ? MODE_W'($urandom_range(MD_INS_HEAD, MD_INS_AT)) :
                         (r < 55) ? MODE_W'($urandom_range(MD_RM_HEAD, MD_RM_AT)) :
                         (r < 97) ? MODE_W'($urandom_range(MD_READ, MD_SWAP)) :
                         (r < 98) ? MD_CLEAR :
                                    MODE_W'($urandom_range(MD_UNUSED_FIRST, MD_UNUSED_LAST));
            endcase

            v = ($urandom_range(9) < 7) ? pool[3'($urandom_range(7))] : $urandom;

            // mostly positions that land inside the list, now and then anything
            hi = (md == MD_INS_AT) ? list_len : list_len - 1;
            if (hi < 0)
                hi = 0;
            if (hi > 15)
                hi = 15;
            p = ($urandom_range(99) < 85) ? POS_W'($urandom_range(hi)) :
                                            POS_W'($urandom_range(15));
            q = ($urandom_range(99) < 85) ? POS_W'($urandom_range(hi)) :
                                            POS_W'($urandom_range(15));

            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                // one phase runs flat out
                if (phase != 4)
                begin
                    gap = ($urandom_range(4) == 0) ? $urandom_range(10, 40) :
                                                     $urandom_range(1, 6);
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            issue(md, v, p, q);
        end

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Drove %0d commands (%0d directed): all twelve operations, spare codes,",
                 sent, directed_n);
        $display("empty and full lists, in-range and stray positions; %0d replies compared",
                 replies);
        if (errors == 0)
            $display("positional_list_engine_test: clean");
        else
            $display("positional_list_engine_test: errors");
        $finish;
    end

endmodule
